// File: sv/sirt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables for the radix text core
// no dependencies

package sirt_pkg;

  localparam int MaxSymbols = 16;  // symbol slots in the two symbol registers
  localparam int SymW       = 8;   // bits per symbol byte
  localparam int IdxW       = 4;   // bits of a digit value / symbol index
  localparam int MagW       = 32;  // width of the input value
  localparam int CountW     = 5;   // width of the digit_count register
  localparam int MaxDigits  = 32;  // most digits a magnitude can have (radix two)
  localparam int DepthW     = 6;   // holds 0 .. MaxDigits
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] CfgDigitCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSymbolsHigh = 2'd2;

  // bytes that may not be used as a symbol
  localparam logic [SymW-1:0] ChNul   = 8'h00;
  localparam logic [SymW-1:0] ChTab   = 8'h09;
  localparam logic [SymW-1:0] ChNl    = 8'h0A;
  localparam logic [SymW-1:0] ChVt    = 8'h0B;
  localparam logic [SymW-1:0] ChFf    = 8'h0C;
  localparam logic [SymW-1:0] ChCr    = 8'h0D;
  localparam logic [SymW-1:0] ChSpace = 8'h20;
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;

  // one value waiting for conversion
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } item_t;

  // one digit from the converter, least significant first
  typedef struct packed {
    logic [IdxW-1:0] digit;
    logic            last;
    logic            neg;
  } dig_t;

  function automatic logic is_forbidden(input logic [SymW-1:0] c);
    return (c == ChNul) || (c == ChSpace) || (c == ChPlus) || (c == ChMinus) ||
           (c == ChTab) || (c == ChNl) || (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  // floor(2^32 / radix); quotient estimate is then exact or one low
  function automatic logic [MagW-1:0] recip(input logic [CountW-1:0] radix);
    logic [MagW-1:0] r;
    case (radix)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/sirt_front.sv
`timescale 1ns / 1ps
// front end: checks the digit set, takes the sign apart and queues the magnitude
// depends on sirt_pkg

module sirt_front (
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sirt_pkg::MagW-1:0]      value_i,
  input  logic [sirt_pkg::CountW-1:0]           digit_count_i,
  input  logic [2*sirt_pkg::CfgDataW-1:0]       symbols_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output sirt_pkg::item_t                       push_item_o
);
  import sirt_pkg::*;

  logic            set_ok;
  logic [MagW-1:0] raw;

  // all pairs checked in parallel, only slots below digit_count count
  always_comb begin
    set_ok = (digit_count_i >= CountW'(2)) && (digit_count_i <= CountW'(MaxSymbols));
    for (int a = 0; a < MaxSymbols; a++) begin
      if (CountW'(a) < digit_count_i) begin
        if (is_forbidden(symbols_i[a*SymW +: SymW])) set_ok = 1'b0;
        for (int b = a + 1; b < MaxSymbols; b++) begin
          if ((CountW'(b) < digit_count_i) &&
              (symbols_i[a*SymW +: SymW] == symbols_i[b*SymW +: SymW])) set_ok = 1'b0;
        end
      end
    end
  end

  assign raw              = value_i;
  assign push_item_o.neg  = raw[MagW-1];
  assign push_item_o.mag  = raw[MagW-1] ? (MagW'(0) - raw) : raw;

  // an invalid set swallows the beat
  assign push_valid_o = in_valid_i & set_ok;
  assign in_ready_o   = set_ok ? push_ready_i : 1'b1;

endmodule

// File: sv/sirt_fifo.sv
`timescale 1ns / 1ps
// two-entry queue between front end and converter
// depends on sirt_pkg

module sirt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sirt_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sirt_pkg::item_t pop_item_o
);
  import sirt_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_item_i;
  end

endmodule

// File: sv/sirt_conv.sv
`timescale 1ns / 1ps
// converter: peels digits off the magnitude, least significant first
// depends on sirt_pkg (reciprocal table, item and digit types)

module sirt_conv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  sirt_pkg::item_t              pop_item_i,
  input  logic [sirt_pkg::CountW-1:0]  radix_i,
  output logic                         dig_valid_o,
  input  logic                         dig_ready_i,
  output sirt_pkg::dig_t               dig_o
);
  import sirt_pkg::*;

  localparam int RemW = 6;  // remainder estimate stays below twice the radix

  typedef enum logic [1:0] {CvIdle, CvMul, CvOut} state_e;

  state_e          state_q;
  logic [MagW-1:0] mag_q, prod_hi_q;
  logic            neg_q;

  logic            pow2;
  logic [2:0]      sh;
  logic [IdxW-1:0] mask;
  logic [2*MagW-1:0] prod_full;
  logic [RemW-1:0] qr_lo, rem0, rem_fix;
  logic            ge;
  logic [IdxW-1:0] digit;
  logic [MagW-1:0] q_next;

  always_comb begin
    case (radix_i)
      5'd2:    begin pow2 = 1'b1; sh = 3'd1; end
      5'd4:    begin pow2 = 1'b1; sh = 3'd2; end
      5'd8:    begin pow2 = 1'b1; sh = 3'd3; end
      5'd16:   begin pow2 = 1'b1; sh = 3'd4; end
      default: begin pow2 = 1'b0; sh = 3'd0; end
    endcase
  end

  assign mask      = ~({IdxW{1'b1}} << sh);
  assign prod_full = mag_q * recip(radix_i);

  // remainder from the registered quotient estimate, then one correction
  assign qr_lo   = RemW'(prod_hi_q[RemW-1:0] * RemW'(radix_i));
  assign rem0    = mag_q[RemW-1:0] - qr_lo;
  assign ge      = (rem0 >= RemW'(radix_i));
  assign rem_fix = rem0 - RemW'(radix_i);

  always_comb begin
    if (pow2) begin
      digit  = mag_q[IdxW-1:0] & mask;
      q_next = mag_q >> sh;
    end else begin
      digit  = ge ? rem_fix[IdxW-1:0] : rem0[IdxW-1:0];
      q_next = ge ? (prod_hi_q + MagW'(1)) : prod_hi_q;
    end
  end

  assign pop_ready_o = (state_q == CvIdle);
  assign dig_valid_o = (state_q == CvOut);
  assign dig_o.digit = digit;
  assign dig_o.last  = (q_next == '0);
  assign dig_o.neg   = neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CvIdle;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      prod_hi_q <= '0;
    end else begin
      case (state_q)
        CvIdle: begin
          if (pop_valid_i) begin
            mag_q   <= pop_item_i.mag;
            neg_q   <= pop_item_i.neg;
            state_q <= pow2 ? CvOut : CvMul;
          end
        end
        CvMul: begin
          prod_hi_q <= prod_full[2*MagW-1:MagW];
          state_q   <= CvOut;
        end
        CvOut: begin
          if (dig_ready_i) begin
            mag_q <= q_next;
            if (q_next == '0) state_q <= CvIdle;
            else              state_q <= pow2 ? CvOut : CvMul;
          end
        end
        default: state_q <= CvIdle;
      endcase
    end
  end

endmodule

// File: sv/sirt_emit.sv
`timescale 1ns / 1ps
// emitter: two digit stacks, one filling while the other drains in reverse,
// plus the output register; depends on sirt_pkg

module sirt_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               dig_valid_i,
  output logic                               dig_ready_o,
  input  sirt_pkg::dig_t                     dig_i,
  input  logic [2*sirt_pkg::CfgDataW-1:0]    symbols_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sirt_pkg::SymW-1:0]          character_o,
  output logic                               last_o
);
  import sirt_pkg::*;

  logic [IdxW-1:0]   stk_q [2][MaxDigits];
  logic [DepthW-1:0] cnt_q [2];
  logic [1:0]        neg_q, full_q;
  logic              wr_sel_q, rd_sel_q;
  logic              out_valid_q, last_q;
  logic [SymW-1:0]   char_q;

  logic            fill, out_load, drain, sign_step;
  logic [IdxW-1:0] top_digit;
  logic [SymW-1:0] top_sym;

  assign dig_ready_o = ~full_q[wr_sel_q];
  assign fill        = dig_valid_i & dig_ready_o;
  assign out_load    = ~out_valid_q | out_ready_i;
  assign drain       = full_q[rd_sel_q] & out_load;
  assign sign_step   = neg_q[rd_sel_q];
  assign top_digit   = stk_q[rd_sel_q][0];
  assign top_sym     = symbols_i[{top_digit, 3'b000} +: SymW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      neg_q       <= '0;
      full_q      <= '0;
      wr_sel_q    <= 1'b0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (fill) begin
        cnt_q[wr_sel_q] <= cnt_q[wr_sel_q] + DepthW'(1);
        if (dig_i.last) begin
          full_q[wr_sel_q] <= 1'b1;
          neg_q[wr_sel_q]  <= dig_i.neg;
          wr_sel_q         <= ~wr_sel_q;
        end
      end
      if (drain) begin
        if (sign_step) begin
          neg_q[rd_sel_q] <= 1'b0;
        end else begin
          cnt_q[rd_sel_q] <= cnt_q[rd_sel_q] - DepthW'(1);
          if (cnt_q[rd_sel_q] == DepthW'(1)) begin
            full_q[rd_sel_q] <= 1'b0;
            rd_sel_q         <= ~rd_sel_q;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= drain;
        char_q      <= sign_step ? ChMinus : top_sym;
        last_q      <= ~sign_step & (cnt_q[rd_sel_q] == DepthW'(1));
      end
    end
  end

  // stack payload: push shifts up, pop shifts down
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 2; b++) begin
      if (fill && (wr_sel_q == 1'(b))) begin
        stk_q[b][0] <= dig_i.digit;
        for (int i = 1; i < MaxDigits; i++) stk_q[b][i] <= stk_q[b][i-1];
      end else if (drain && !sign_step && (rd_sel_q == 1'(b))) begin
        for (int i = 0; i < MaxDigits - 1; i++) stk_q[b][i] <= stk_q[b][i+1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// File: sv/signed_integer_to_radix_text_core.sv
`timescale 1ns / 1ps
// top level: signed 32-bit value to text in a configured radix and alphabet
// depends on sirt_pkg, sirt_front, sirt_fifo, sirt_conv, sirt_emit
//
//  channel | signals                                          | beat
//  --------+--------------------------------------------------+-------------------------
//  in      | in_valid_i  in_ready_o  value_i                  | one signed value
//  out     | out_valid_o out_ready_i character_o last_o       | one text byte
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   | one register write
//
// the front end takes a value each cycle while the queue has room; values with an
// invalid digit set are taken and dropped without output
// the converter loads a value, then gives each digit straight from the magnitude for a
// power-of-two radix, or through a reciprocal multiply and then a remainder fix-up
// otherwise; it takes no new value until the last digit of the current one is out
// bytes leave one per cycle while out_ready_i is high and a whole value is stacked,
// sign first, from one of two digit stacks while the other fills; at most 33 per value
// reset clears the config registers and all control state (not the queue or stack
// payload), no clearing pass is needed; either side may stall at any time, the queue and stacks absorb it

module signed_integer_to_radix_text_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sirt_pkg::MagW-1:0]   value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sirt_pkg::SymW-1:0]          character_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sirt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sirt_pkg::CfgDataW-1:0]      cfg_data_i
);
  import sirt_pkg::*;

  // config registers
  logic [CountW-1:0]     digit_count_q;
  logic [CfgDataW-1:0]   symbols_low_q, symbols_high_q;
  logic [2*CfgDataW-1:0] symbols;

  // front to queue
  logic  push_valid, push_ready;
  item_t push_item;
  // queue to converter
  logic  pop_valid, pop_ready;
  item_t pop_item;
  // converter to emitter
  logic  dig_valid, dig_ready;
  dig_t  dig;

  assign cfg_ready_o = 1'b1;
  assign symbols     = {symbols_high_q, symbols_low_q};

  // writes to an unknown index are taken and ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q  <= '0;
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDigitCount:  digit_count_q  <= cfg_data_i[CountW-1:0];
        CfgSymbolsLow:  symbols_low_q  <= cfg_data_i;
        CfgSymbolsHigh: symbols_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify and split sign from magnitude
  sirt_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .digit_count_i (digit_count_q),
    .symbols_i     (symbols),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // decouples the front end from the converter
  sirt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // repeated division by the radix
  sirt_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .radix_i     (digit_count_q),
    .dig_valid_o (dig_valid),
    .dig_ready_i (dig_ready),
    .dig_o       (dig)
  );

  // reverse digit order, map to symbols, drive the output
  sirt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dig_valid_i (dig_valid),
    .dig_ready_o (dig_ready),
    .dig_i       (dig),
    .symbols_i   (symbols),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
